// ===== design/sht_pkg.sv =====
// Package for the scheduled hysteresis thermostat: field widths, register
// indexes, run modes and the invalid sample codes.
// No dependencies.
`default_nettype none

package sht_pkg;

  // field widths
  localparam int unsigned TEMP_W      = 13;
  localparam int unsigned HOUR_W      = 5;
  localparam int unsigned MINUTE_W    = 6;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 13;
  localparam int unsigned FAULT_CNT_W = 6;

  // default number of invalid samples before the saved value is overwritten
  localparam int unsigned FAULT_LIMIT_DEF = 60;

  // sensor codes that mark a broken or missing reading
  localparam logic signed [TEMP_W-1:0] BAD_SAMPLE_A = 13'sd0;
  localparam logic signed [TEMP_W-1:0] BAD_SAMPLE_B = 13'sd850;
  localparam logic signed [TEMP_W-1:0] BAD_SAMPLE_C = 13'sd2550;

  // saved temperature after reset
  localparam logic signed [TEMP_W-1:0] SAVED_TEMP_RST = 13'sd1;

  // clock limits
  localparam logic [HOUR_W-1:0]   MAX_HOUR      = 5'd23;
  localparam logic [MINUTE_W-1:0] MAX_MINUTE    = 6'd59;
  localparam logic [HOUR_W-1:0]   HOURS_PER_DAY = 5'd24;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DAY_LOW      = 3'd0,
    REG_DAY_HIGH     = 3'd1,
    REG_NIGHT_LOW    = 3'd2,
    REG_NIGHT_HIGH   = 3'd3,
    REG_WINDOW_START = 3'd4,
    REG_WINDOW_END   = 3'd5,
    REG_RUN_MODE     = 3'd6
  } cfg_reg_e;

  // run modes
  typedef enum logic [1:0] {
    MODE_OFF    = 2'd0,
    MODE_COOLER = 2'd1,
    MODE_HEATER = 2'd2,
    MODE_ON     = 2'd3
  } run_mode_e;

  // hour or minute out of range is stored as 0
  function automatic logic [HOUR_W-1:0] clip_hour(input logic [HOUR_W-1:0] h);
    clip_hour = (h > MAX_HOUR) ? '0 : h;
  endfunction

  function automatic logic [MINUTE_W-1:0] clip_minute(input logic [MINUTE_W-1:0] m);
    clip_minute = (m > MAX_MINUTE) ? '0 : m;
  endfunction

endpackage

`default_nettype wire

// ===== design/scheduled_hysteresis_thermostat.sv =====
// Scheduled hysteresis thermostat: input register, sample check, time window,
// hysteresis latch and result register in one module.
// Depends on sht_pkg.
//
// Usage:
// - Input channel: in_valid_i with temperature_i, hour_i, minute_i; the block
//   raises in_stall_o when it cannot take the item. Accepted when valid is
//   high and stall is low.
// - Output channel: out_valid_o with relay_o, in_window_o, sample_ok_o; the
//   receiver raises out_stall_i to hold the result.
// - Configuration: cfg_we_i writes cfg_data_i into register cfg_index_i at
//   the clock edge; an unknown index is ignored. Write only while idle.
// - Path: the input register feeds one pass of compare logic into the result
//   register, and the thermostat state is updated as the item moves into the
//   result register.
// - Throughput: one item per cycle while the result side is not stalled.
// - Stalling: while the result register is full and stalled, the item in the
//   input register waits and in_stall_o goes high; nothing is dropped.
// - Reset: all configuration registers read 0, the saved temperature is 1,
//   the fault count and relay latch are 0 and both channels are empty.
`default_nettype none

module scheduled_hysteresis_thermostat
  import sht_pkg::*;
#(
  parameter int unsigned FAULT_LIMIT = FAULT_LIMIT_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // configuration write port
  input  wire logic                         cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]         cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0]        cfg_data_i,
  // input channel
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic signed [TEMP_W-1:0]     temperature_i,
  input  wire logic [HOUR_W-1:0]            hour_i,
  input  wire logic [MINUTE_W-1:0]          minute_i,
  // output channel
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic                              relay_o,
  output logic                              in_window_o,
  output logic                              sample_ok_o
);

  localparam logic [FAULT_CNT_W-1:0] FaultLimit = FAULT_CNT_W'(FAULT_LIMIT);

  // configuration registers
  logic signed [TEMP_W-1:0] day_low_q, day_high_q, night_low_q, night_high_q;
  logic [HOUR_W-1:0]        start_hour_q, end_hour_q;
  logic [MINUTE_W-1:0]      start_min_q, end_min_q;
  run_mode_e                run_mode_q;

  // thermostat state
  logic signed [TEMP_W-1:0] saved_temp_q, saved_temp_d;
  logic [FAULT_CNT_W-1:0]   fault_cnt_q, fault_cnt_d, fault_cnt_inc;
  logic                     relay_latch_q, relay_latch_d;

  // input register
  logic                     s1_valid_q;
  logic signed [TEMP_W-1:0] s1_temp_q;
  logic [HOUR_W-1:0]        s1_hour_q;
  logic [MINUTE_W-1:0]      s1_min_q;

  // result register
  logic out_valid_q, out_relay_q, out_window_q, out_ok_q;

  logic advance, in_accept;
  logic sample_ok, day, from_start, to_end;
  logic signed [TEMP_W-1:0] lo_thr, hi_thr;
  logic above_hi, below_lo;

  // handshake: the input register moves on when the result register frees up
  assign advance    = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      day_low_q    <= '0;
      day_high_q   <= '0;
      night_low_q  <= '0;
      night_high_q <= '0;
      start_hour_q <= '0;
      start_min_q  <= '0;
      end_hour_q   <= '0;
      end_min_q    <= '0;
      run_mode_q   <= MODE_OFF;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_DAY_LOW:    day_low_q    <= cfg_data_i;
        REG_DAY_HIGH:   day_high_q   <= cfg_data_i;
        REG_NIGHT_LOW:  night_low_q  <= cfg_data_i;
        REG_NIGHT_HIGH: night_high_q <= cfg_data_i;
        REG_WINDOW_START: begin
          start_hour_q <= clip_hour(cfg_data_i[MINUTE_W+HOUR_W-1:MINUTE_W]);
          start_min_q  <= clip_minute(cfg_data_i[MINUTE_W-1:0]);
        end
        REG_WINDOW_END: begin
          end_hour_q <= clip_hour(cfg_data_i[MINUTE_W+HOUR_W-1:MINUTE_W]);
          end_min_q  <= clip_minute(cfg_data_i[MINUTE_W-1:0]);
        end
        REG_RUN_MODE:   run_mode_q <= run_mode_e'(cfg_data_i[1:0]);
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
    end else if (advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_temp_q <= temperature_i;
      s1_hour_q <= hour_i;
      s1_min_q  <= minute_i;
    end
  end

  // sample check and fault counter
  always_comb begin
    sample_ok = (s1_temp_q != BAD_SAMPLE_A) && (s1_temp_q != BAD_SAMPLE_B) &&
                (s1_temp_q != BAD_SAMPLE_C);
    fault_cnt_inc = fault_cnt_q + FAULT_CNT_W'(1);
    saved_temp_d  = sample_ok ? s1_temp_q : saved_temp_q;
    fault_cnt_d   = sample_ok ? fault_cnt_q : fault_cnt_inc;
    if (fault_cnt_d >= FaultLimit) begin
      saved_temp_d = s1_temp_q;
      fault_cnt_d  = '0;
    end
  end

  // time window, wrapping past midnight when start hour is not below end hour
  always_comb begin
    from_start = (s1_hour_q == start_hour_q) && (start_min_q <= s1_min_q);
    to_end     = (s1_hour_q == end_hour_q) && (s1_min_q < end_min_q);
    if (start_hour_q < end_hour_q) begin
      day = from_start || to_end ||
            ((start_hour_q < s1_hour_q) && (s1_hour_q < end_hour_q));
    end else begin
      day = from_start || to_end || (s1_hour_q < end_hour_q) ||
            ((start_hour_q < s1_hour_q) && (s1_hour_q < HOURS_PER_DAY));
    end
    lo_thr = day ? day_low_q : night_low_q;
    hi_thr = day ? day_high_q : night_high_q;
  end

  // hysteresis latch, lower threshold compare decides when both hit
  always_comb begin
    above_hi      = hi_thr < saved_temp_d;
    below_lo      = saved_temp_d < lo_thr;
    relay_latch_d = relay_latch_q;
    unique case (run_mode_q)
      MODE_OFF: relay_latch_d = 1'b0;
      MODE_COOLER: begin
        if (above_hi) relay_latch_d = 1'b1;
        if (below_lo) relay_latch_d = 1'b0;
      end
      MODE_HEATER: begin
        if (above_hi) relay_latch_d = 1'b0;
        if (below_lo) relay_latch_d = 1'b1;
      end
      MODE_ON: relay_latch_d = 1'b1;
      default: relay_latch_d = relay_latch_q;
    endcase
  end

  // state update as the item moves into the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      saved_temp_q  <= SAVED_TEMP_RST;
      fault_cnt_q   <= '0;
      relay_latch_q <= 1'b0;
    end else if (advance) begin
      saved_temp_q  <= saved_temp_d;
      fault_cnt_q   <= fault_cnt_d;
      relay_latch_q <= relay_latch_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_relay_q  <= relay_latch_d;
      out_window_q <= day;
      out_ok_q     <= sample_ok;
    end
  end

  assign out_valid_o = out_valid_q;
  assign relay_o     = out_relay_q;
  assign in_window_o = out_window_q;
  assign sample_ok_o = out_ok_q;

`ifndef SYNTHESIS
  // fault counter never reaches the limit between items
  a_fault_below_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fault_cnt_q < FaultLimit)
    else $error("fault counter at or above limit");

  // the last tolerated invalid sample wraps the counter back to zero
  a_fault_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && !sample_ok && (fault_cnt_inc == FaultLimit) |=> fault_cnt_q == '0)
    else $error("fault counter did not restart at limit");

  // off mode forces the delivered relay level low
  a_mode_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && (run_mode_q == MODE_OFF) |=> !relay_o && out_valid_o)
    else $error("relay on in off mode");

  // input side stalls only while an item waits in the input register
  a_stall_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q && out_valid_q)
    else $error("input stalled without a waiting item");

  // delivered relay level matches the latch state
  a_relay_latch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> relay_o == relay_latch_q)
    else $error("delivered relay level differs from latch");
`endif

endmodule

`default_nettype wire

// ===== test/thermostat_checker.sv =====
// Result checker for the scheduled hysteresis thermostat: tracks register
// writes, predicts each result from the accepted items and compares.
// Depends on sht_pkg.
`timescale 1ns / 100ps

module thermostat_checker
  import sht_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                     in_valid_i,
  input  logic                     in_stall_i,
  input  logic signed [TEMP_W-1:0] temperature_i,
  input  logic [HOUR_W-1:0]        hour_i,
  input  logic [MINUTE_W-1:0]      minute_i,
  input  logic                     out_valid_i,
  input  logic                     out_stall_i,
  input  logic                     relay_i,
  input  logic                     in_window_i,
  input  logic                     sample_ok_i,
  output int                       errors_o,
  output int                       pending_o
);

  typedef struct packed {
    logic relay;
    logic in_window;
    logic sample_ok;
  } thermostat_result_t;

  // register copies
  logic signed [TEMP_W-1:0] day_low, day_high, night_low, night_high;
  logic [HOUR_W-1:0]        start_hour, end_hour;
  logic [MINUTE_W-1:0]      start_minute, end_minute;
  run_mode_e                mode;

  // thermostat state
  logic signed [TEMP_W-1:0] saved_temp;
  logic [FAULT_CNT_W-1:0]   fault_count;
  logic                     relay_latch;

  thermostat_result_t expected_results[$];

  // day window test, wrapping past midnight when start hour is not below end hour
  function automatic logic day_window(input logic [HOUR_W-1:0] h,
                                      input logic [MINUTE_W-1:0] m);
    logic from_start, to_end;
    from_start = (h == start_hour) && (start_minute <= m);
    to_end     = (h == end_hour) && (m < end_minute);
    if (start_hour < end_hour)
      return from_start || (start_hour < h && h < end_hour) || to_end;
    return from_start || (start_hour < h && h < HOURS_PER_DAY) || (h < end_hour) || to_end;
  endfunction

  // one sample through the fault counter, window select and relay latch
  function automatic thermostat_result_t advance_thermostat(
      input logic signed [TEMP_W-1:0] t,
      input logic [HOUR_W-1:0]        h,
      input logic [MINUTE_W-1:0]      m);
    thermostat_result_t       r;
    logic signed [TEMP_W-1:0] lo, hi;
    r.sample_ok = (t != BAD_SAMPLE_A) && (t != BAD_SAMPLE_B) && (t != BAD_SAMPLE_C);
    if (r.sample_ok) saved_temp = t;
    else fault_count = fault_count + 1'b1;
    // too many bad samples: the bad value is taken anyway
    if (fault_count >= FAULT_LIMIT_DEF) begin
      saved_temp  = t;
      fault_count = '0;
    end
    r.in_window = day_window(h, m);
    lo = r.in_window ? day_low : night_low;
    hi = r.in_window ? day_high : night_high;
    // low compare comes last so it wins when both hold
    case (mode)
      MODE_OFF: relay_latch = 1'b0;
      MODE_COOLER: begin
        if (hi < saved_temp) relay_latch = 1'b1;
        if (saved_temp < lo) relay_latch = 1'b0;
      end
      MODE_HEATER: begin
        if (hi < saved_temp) relay_latch = 1'b0;
        if (saved_temp < lo) relay_latch = 1'b1;
      end
      default: relay_latch = 1'b1;
    endcase
    r.relay = relay_latch;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    thermostat_result_t want;
    if (!rst_ni) begin
      day_low      = '0;
      day_high     = '0;
      night_low    = '0;
      night_high   = '0;
      start_hour   = '0;
      start_minute = '0;
      end_hour     = '0;
      end_minute   = '0;
      mode         = MODE_OFF;
      saved_temp   = SAVED_TEMP_RST;
      fault_count  = '0;
      relay_latch  = 1'b0;
      expected_results.delete();
      pending_o    = 0;
    end else begin
      // compare an accepted result with the oldest expectation
      if (out_valid_i && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          $error("result item with nothing expected");
          errors_o++;
        end else begin
          want = expected_results.pop_front();
          if (relay_i !== want.relay) begin
            $error("relay: expected %0b, got %0b", want.relay, relay_i);
            errors_o++;
          end
          if (in_window_i !== want.in_window) begin
            $error("in_window: expected %0b, got %0b", want.in_window, in_window_i);
            errors_o++;
          end
          if (sample_ok_i !== want.sample_ok) begin
            $error("sample_ok: expected %0b, got %0b", want.sample_ok, sample_ok_i);
            errors_o++;
          end
        end
      end

      // register writes, out-of-range window fields stored as 0
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_DAY_LOW:    day_low    = cfg_data_i;
          REG_DAY_HIGH:   day_high   = cfg_data_i;
          REG_NIGHT_LOW:  night_low  = cfg_data_i;
          REG_NIGHT_HIGH: night_high = cfg_data_i;
          REG_WINDOW_START: begin
            start_hour   = (cfg_data_i[10:6] > MAX_HOUR) ? '0 : cfg_data_i[10:6];
            start_minute = (cfg_data_i[5:0] > MAX_MINUTE) ? '0 : cfg_data_i[5:0];
          end
          REG_WINDOW_END: begin
            end_hour   = (cfg_data_i[10:6] > MAX_HOUR) ? '0 : cfg_data_i[10:6];
            end_minute = (cfg_data_i[5:0] > MAX_MINUTE) ? '0 : cfg_data_i[5:0];
          end
          REG_RUN_MODE: mode = run_mode_e'(cfg_data_i[1:0]);
          default: ;
        endcase
      end

      // predict from each accepted item
      if (in_valid_i && !in_stall_i)
        expected_results.push_back(advance_thermostat(temperature_i, hour_i, minute_i));
      pending_o = expected_results.size();
    end
  end

endmodule

// ===== test/testbench.sv =====
// Top of the thermostat testbench: clock, reset, item and register stimulus,
// random stalls and the verdict.
// Depends on sht_pkg, scheduled_hysteresis_thermostat and thermostat_checker.
`timescale 1ns / 100ps

module testbench;
  import sht_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;
  localparam int CYCLE_LIMIT     = 200000;
  localparam int RANDOM_PHASES   = 10;
  localparam int ITEMS_PER_PHASE = 123;
  localparam int HOLD_CYCLES     = 300;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     cfg_we_i;
  logic [CFG_IDX_W-1:0]     cfg_index_i;
  logic [CFG_DATA_W-1:0]    cfg_data_i;
  logic                     in_valid_i;
  logic                     in_stall_o;
  logic signed [TEMP_W-1:0] temperature_i;
  logic [HOUR_W-1:0]        hour_i;
  logic [MINUTE_W-1:0]      minute_i;
  logic                     out_valid_o;
  logic                     out_stall_i;
  logic                     relay_o;
  logic                     in_window_o;
  logic                     sample_ok_o;

  int errors;
  int pending;
  int cycles = 0;
  bit idle_on;
  bit hold_go;

  scheduled_hysteresis_thermostat dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .temperature_i (temperature_i),
    .hour_i        (hour_i),
    .minute_i      (minute_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .relay_o       (relay_o),
    .in_window_o   (in_window_o),
    .sample_ok_o   (sample_ok_o)
  );

  thermostat_checker result_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_i    (in_stall_o),
    .temperature_i (temperature_i),
    .hour_i        (hour_i),
    .minute_i      (minute_i),
    .out_valid_i   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .relay_i       (relay_o),
    .in_window_i   (in_window_o),
    .sample_ok_i   (sample_ok_o),
    .errors_o      (errors),
    .pending_o     (pending)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  // result side: random stalls plus one long hold-off
  initial begin : receiver
    int hold_left;
    bit hold_done;
    out_stall_i = 1'b0;
    hold_left   = 0;
    hold_done   = 0;
    forever begin
      @(negedge clk_i);
      if (hold_go && !hold_done) begin
        hold_done = 1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= idle_on && ($urandom_range(99) < 11);
      end
    end
  end

  // offer one item, with random gaps, until accepted
  task automatic offer_item(input int t, input int h, input int m);
    @(negedge clk_i);
    while (idle_on && $urandom_range(99) < 11) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    temperature_i <= TEMP_W'(t);
    hour_i        <= HOUR_W'(h);
    minute_i      <= MINUTE_W'(m);
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // stop offering and wait until every result has come out
  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic set_thresholds(input int dl, input int dh, input int nl, input int nh);
    write_reg(REG_DAY_LOW, TEMP_W'(dl));
    write_reg(REG_DAY_HIGH, TEMP_W'(dh));
    write_reg(REG_NIGHT_LOW, TEMP_W'(nl));
    write_reg(REG_NIGHT_HIGH, TEMP_W'(nh));
  endtask

  // spare top bits get random values, they must not matter
  task automatic set_window(input int sh, input int sm, input int eh, input int em);
    write_reg(REG_WINDOW_START, {2'($urandom), HOUR_W'(sh), MINUTE_W'(sm)});
    write_reg(REG_WINDOW_END, {2'($urandom), HOUR_W'(eh), MINUTE_W'(em)});
  endtask

  task automatic set_mode(input run_mode_e mode);
    write_reg(REG_RUN_MODE, {11'($urandom), mode});
  endtask

  initial begin : stimulus
    int base, gap, dl, dh, nl, nh, band_lo, band_hi, bad_pct;
    int win_sh, win_sm, win_eh, win_em, t, h, m, r;
    run_mode_e mode;

    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    in_valid_i    = 1'b0;
    temperature_i = '0;
    hour_i        = '0;
    minute_i      = '0;
    idle_on       = 1;
    hold_go       = 0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: bad sample codes and field extremes
    offer_item(0, 0, 0);
    offer_item(850, 12, 30);
    offer_item(2550, 23, 59);
    offer_item(4095, 31, 63);
    offer_item(-4096, 24, 0);
    offer_item(1, 0, 0);

    // cooler, extreme day thresholds, plain window 8:30 to 20:00
    settle();
    set_thresholds(-4096, 4095, 100, 200);
    set_window(8, 30, 20, 0);
    set_mode(MODE_COOLER);
    write_reg(REG_SPARE, '1);
    offer_item(250, 8, 29);
    offer_item(150, 8, 30);
    offer_item(50, 19, 59);
    offer_item(50, 20, 0);
    offer_item(150, 31, 0);

    // low above high so both compares hold, window wrapping past midnight
    settle();
    set_thresholds(300, 100, 100, 200);
    set_window(22, 15, 6, 45);
    offer_item(200, 23, 0);
    offer_item(200, 26, 10);
    offer_item(201, 6, 44);

    // heater, out-of-range window fields stored as zero
    settle();
    set_thresholds(300, 100, -4096, 4095);
    set_window(31, 63, 7, 62);
    set_mode(MODE_HEATER);
    offer_item(50, 0, 0);
    offer_item(4095, 6, 59);
    offer_item(-4096, 7, 0);

    // equal start and end hours
    settle();
    set_window(7, 10, 7, 5);
    offer_item(500, 7, 7);
    offer_item(500, 7, 12);

    // forced on and off
    settle();
    set_mode(MODE_ON);
    offer_item(850, 3, 3);
    settle();
    set_mode(MODE_OFF);
    offer_item(-1, 13, 13);

    // random phases, each with its own settings
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      settle();
      base = int'($urandom_range(3000)) - 1000;
      gap  = int'($urandom_range(150));
      dl   = base;
      dh   = base + gap;
      nl   = base + int'($urandom_range(100)) - 50;
      nh   = nl + int'($urandom_range(150));
      if ($urandom_range(7) == 0) begin
        dl = base + gap;
        dh = base;
      end
      if ($urandom_range(5) == 0) begin
        nl = -4096;
        nh = 4095;
      end
      band_lo = base - 120;
      band_hi = base + gap + 120;
      set_thresholds(dl, dh, nl, nh);

      win_sh = ($urandom_range(9) == 0) ? $urandom_range(31, 24) : $urandom_range(23);
      win_sm = ($urandom_range(9) == 0) ? $urandom_range(63, 60) : $urandom_range(59);
      win_eh = ($urandom_range(9) == 0) ? $urandom_range(31, 24) : $urandom_range(23);
      win_em = ($urandom_range(9) == 0) ? $urandom_range(63, 60) : $urandom_range(59);
      set_window(win_sh, win_sm, win_eh, win_em);

      r = $urandom_range(9);
      if (r == 0) mode = MODE_OFF;
      else if (r == 1) mode = MODE_ON;
      else if (r < 6) mode = MODE_COOLER;
      else mode = MODE_HEATER;
      set_mode(mode);
      if ($urandom_range(3) == 0) write_reg(REG_SPARE, 13'($urandom));

      bad_pct = $urandom_range(40, 5);
      idle_on = (p != 4);
      if (p == 2) hold_go = 1;

      repeat (ITEMS_PER_PHASE) begin
        // samples mostly around the thresholds, some bad codes, some anything
        r = $urandom_range(99);
        if (r < bad_pct) begin
          case ($urandom_range(2))
            0:       t = BAD_SAMPLE_A;
            1:       t = BAD_SAMPLE_B;
            default: t = BAD_SAMPLE_C;
          endcase
        end else if (r < bad_pct + 20) begin
          t = int'($urandom_range(8191)) - 4096;
        end else begin
          t = band_lo + int'($urandom_range(band_hi - band_lo));
        end
        // clock often on the window edges
        r = $urandom_range(99);
        if (r < 30) h = $urandom_range(1) ? win_sh : win_eh;
        else if (r < 92) h = $urandom_range(23);
        else h = $urandom_range(31);
        r = $urandom_range(99);
        if (r < 30) begin
          m = ($urandom_range(1) ? win_sm : win_em) + int'($urandom_range(2)) - 1;
          if (m < 0) m = 0;
        end else if (r < 92) begin
          m = $urandom_range(59);
        end else begin
          m = $urandom_range(63);
        end
        offer_item(t, h, m);
      end
    end

    settle();
    if (errors == 0) $display("testbench: clean");
    else $display("testbench: errors");
    $finish;
  end

endmodule
